/* rtl/core/fbm_pkg.sv */
// Shared types and constants for the bank mapper with scanline interrupt.
`default_nettype none
package fbm_pkg;

  localparam int CntW   = 16;
  localparam int UnitsW = 8;
  localparam int SelW   = 4;
  localparam int PageW  = 5;

  localparam logic [1:0] CMD_EXP  = 2'd0;
  localparam logic [1:0] CMD_PRG  = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [15:0] ADDR_MIRROR_A = 16'h42fe;
  localparam logic [15:0] ADDR_MIRROR_B = 16'h42ff;
  localparam logic [15:0] ADDR_IRQ_OFF  = 16'h4501;
  localparam logic [15:0] ADDR_CNT_LO   = 16'h4502;
  localparam logic [15:0] ADDR_CNT_HI   = 16'h4503;

  localparam logic [UnitsW-1:0] UNITS_RESET = 8'd16;
  localparam logic [CntW-1:0]   TICK_STEP   = 16'd133;
  localparam logic [CntW-1:0]   CNT_LIMIT   = 16'hffff;

  // operand request into the shared add/subtract unit
  typedef struct packed {
    logic [CntW-1:0] a;
    logic [CntW-1:0] b;
    logic            sub;
  } alu_req_t;

  typedef struct packed {
    logic [CntW-1:0] y;
    logic            carry;  // carry out on add, no-borrow on subtract
  } alu_rsp_t;

endpackage
`default_nettype wire

/* rtl/core/ffe_bank_mapper_with_scanline_irq.sv */
// Top level of the bank mapper with scanline interrupt counter.
// Each request is one CPU expansion-register write, one program-space write, one
// scanline tick or a spare code that only reports state, and yields exactly one result
// carrying the current program pages, character bank, mirroring code and the interrupt
// pulse. A single add/subtract unit does all arithmetic under a small sequencer: a
// program-space write runs four restoring shift-subtract steps that reduce the bank
// number modulo the ROM size; an enabled tick adds the step, then compares against the
// limit. One request is in work at a time; the finished result sits in an output
// register, so the next request is taken while it waits. The user is to write the ROM
// size register through the cfg port while the block is idle; the block does not enforce it.
`default_nettype none
module ffe_bank_mapper_with_scanline_irq (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 cmd,
  input  wire logic [15:0]                addr,
  input  wire logic [7:0]                 wdata,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [fbm_pkg::PageW-1:0]       prg_page_lo,
  output logic [fbm_pkg::PageW-1:0]       prg_page_hi,
  output logic [1:0]                      chr_bank,
  output logic [1:0]                      mirror_mode,
  output logic                            irq_pulse,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [fbm_pkg::UnitsW-1:0] cfg_data
);
  import fbm_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_ADD  = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]        state;
  logic [UnitsW-1:0] prg_rom_units;

  // architectural mapper state
  logic [SelW-1:0] prg_select;
  logic [1:0]      chr_select;
  logic [1:0]      mirror_reg;
  logic            irq_on;
  logic [CntW-1:0] irq_count;

  // working registers of the sequencer
  logic [SelW-1:0]   div_sel;   // bank bits still to shift in, msb first
  logic [UnitsW-1:0] div_rem;   // partial remainder
  logic [1:0]        div_step;
  logic [CntW-1:0]   tick_sum;
  logic              tick_ovf;
  logic              pulse;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  logic [UnitsW:0]   trial;

  fbm_addsub u_addsub (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // shift the next bank bit into the remainder; subtract the ROM size if it fits.
  // A ROM size of zero subtracts nothing, which leaves the bank unreduced.
  assign trial = {div_rem, div_sel[SelW-1]};

  always_comb begin
    alu_req.a   = {{(CntW-UnitsW-1){1'b0}}, trial};
    alu_req.b   = {{(CntW-UnitsW){1'b0}}, prg_rom_units};
    alu_req.sub = 1'b1;
    unique case (state)
      ST_ADD: begin
        alu_req.a   = irq_count;
        alu_req.b   = TICK_STEP;
        alu_req.sub = 1'b0;
      end
      ST_CMP: begin
        alu_req.a   = tick_sum;
        alu_req.b   = CNT_LIMIT;
        alu_req.sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      prg_rom_units <= UNITS_RESET;
      prg_select    <= '0;
      chr_select    <= '0;
      mirror_reg    <= '0;
      irq_on        <= 1'b0;
      irq_count     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        prg_rom_units <= cfg_data;
      end
      // drop the taken result unless a new one is loaded in this cycle
      if (out_valid && out_ready && state != ST_FIN) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            pulse <= 1'b0;
            case (cmd)
              CMD_EXP: begin
                state <= ST_FIN;
                unique case (addr)
                  ADDR_MIRROR_A: mirror_reg <= wdata[4] ? 2'd2 : 2'd3;
                  ADDR_MIRROR_B: mirror_reg <= wdata[4] ? 2'd0 : 2'd1;
                  ADDR_IRQ_OFF:  irq_on <= 1'b0;
                  ADDR_CNT_LO:   irq_count[7:0] <= wdata;
                  ADDR_CNT_HI: begin
                    irq_count[15:8] <= wdata;
                    irq_on          <= 1'b1;
                  end
                  default: begin
                  end
                endcase
              end
              CMD_PRG: begin
                div_sel    <= wdata[5:2];
                div_rem    <= '0;
                div_step   <= '0;
                chr_select <= wdata[1:0];
                state      <= ST_DIV;
              end
              CMD_TICK: begin
                state <= irq_on ? ST_ADD : ST_FIN;
              end
              default: begin
                state <= ST_FIN;
              end
            endcase
          end
        end

        ST_DIV: begin
          div_rem  <= alu_rsp.carry ? alu_rsp.y[UnitsW-1:0] : trial[UnitsW-1:0];
          div_sel  <= {div_sel[SelW-2:0], 1'b0};
          div_step <= div_step + 2'd1;
          if (div_step == 2'd3) begin
            prg_select <= alu_rsp.carry ? alu_rsp.y[SelW-1:0] : trial[SelW-1:0];
            state      <= ST_FIN;
          end
        end

        ST_ADD: begin
          tick_sum <= alu_rsp.y;
          tick_ovf <= alu_rsp.carry;
          state    <= ST_CMP;
        end

        ST_CMP: begin
          // the sum reached the limit: pulse and clear, else keep the sum
          if (tick_ovf || alu_rsp.carry) begin
            pulse     <= 1'b1;
            irq_count <= '0;
          end else begin
            irq_count <= tick_sum;
          end
          state <= ST_FIN;
        end

        ST_FIN: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            prg_page_lo <= {prg_select, 1'b0};
            prg_page_hi <= {prg_select, 1'b1};
            chr_bank    <= chr_select;
            mirror_mode <= mirror_reg;
            irq_pulse   <= pulse;
            out_valid   <= 1'b1;
            state       <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/core/fbm_addsub.sv */
// Shared add/subtract unit with carry out.
`default_nettype none
module fbm_addsub (
  input  fbm_pkg::alu_req_t req,
  output fbm_pkg::alu_rsp_t rsp
);
  import fbm_pkg::*;

  logic [CntW-1:0] b_eff;
  logic [CntW:0]   total;

  assign b_eff = req.sub ? ~req.b : req.b;
  assign total = {1'b0, req.a} + {1'b0, b_eff} + {{CntW{1'b0}}, req.sub};
  assign rsp.y     = total[CntW-1:0];
  assign rsp.carry = total[CntW];

endmodule
`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for the bank mapper with scanline interrupt counter.
`timescale 1ns / 100ps

typedef struct packed {
  logic [fbm_pkg::PageW-1:0] page_lo;
  logic [fbm_pkg::PageW-1:0] page_hi;
  logic [1:0]                chr;
  logic [1:0]                mirror;
  logic                      pulse;
} mapper_view_t;

// Tracks the mapper state and the views still owed by the block.
class mapper_scoreboard;
  localparam logic [1:0] MIRROR_A_SET = 2'd2;
  localparam logic [1:0] MIRROR_A_CLR = 2'd3;
  localparam logic [1:0] MIRROR_B_SET = 2'd0;
  localparam logic [1:0] MIRROR_B_CLR = 2'd1;

  logic [fbm_pkg::UnitsW-1:0] rom_units;
  logic [fbm_pkg::SelW-1:0]   bank_sel;
  logic [1:0]                 chr_sel;
  logic [1:0]                 mirror;
  logic                       irq_en;
  logic [fbm_pkg::CntW-1:0]   irq_cnt;
  mapper_view_t               view_q[$];
  int                         errors;
  int                         checked;
  int                         pulses;

  function new();
    rom_units = fbm_pkg::UNITS_RESET;
    bank_sel  = '0;
    chr_sel   = '0;
    mirror    = '0;
    irq_en    = 1'b0;
    irq_cnt   = '0;
    errors    = 0;
    checked   = 0;
    pulses    = 0;
  endfunction

  function void set_units(logic [fbm_pkg::UnitsW-1:0] v);
    rom_units = v;
  endfunction

  function int pending();
    return view_q.size();
  endfunction

  function void note_request(logic [1:0] c, logic [15:0] a, logic [7:0] d);
    mapper_view_t v;
    int           sel;
    logic [16:0]  sum;
    v.pulse = 1'b0;
    case (c)
      fbm_pkg::CMD_EXP: begin
        case (a)
          fbm_pkg::ADDR_MIRROR_A: mirror = d[4] ? MIRROR_A_SET : MIRROR_A_CLR;
          fbm_pkg::ADDR_MIRROR_B: mirror = d[4] ? MIRROR_B_SET : MIRROR_B_CLR;
          fbm_pkg::ADDR_IRQ_OFF:  irq_en = 1'b0;
          fbm_pkg::ADDR_CNT_LO:   irq_cnt[7:0] = d;
          fbm_pkg::ADDR_CNT_HI: begin
            irq_cnt[15:8] = d;
            irq_en        = 1'b1;
          end
          default: ;
        endcase
      end
      fbm_pkg::CMD_PRG: begin
        // reduce now; a later ROM size change leaves the mapping alone
        sel = int'(d[5:2]);
        if (rom_units != 0) sel = sel % int'(rom_units);
        bank_sel = sel[3:0];
        chr_sel  = d[1:0];
      end
      fbm_pkg::CMD_TICK: begin
        if (irq_en) begin
          sum = {1'b0, irq_cnt} + {1'b0, fbm_pkg::TICK_STEP};
          if (sum >= {1'b0, fbm_pkg::CNT_LIMIT}) begin
            v.pulse = 1'b1;
            irq_cnt = '0;
          end else begin
            irq_cnt = sum[15:0];
          end
        end
      end
      default: ;
    endcase
    v.page_lo = {bank_sel, 1'b0};
    v.page_hi = {bank_sel, 1'b0} + 5'd1;
    v.chr     = chr_sel;
    v.mirror  = mirror;
    view_q.push_back(v);
  endfunction

  function void check_result(logic [fbm_pkg::PageW-1:0] lo, logic [fbm_pkg::PageW-1:0] hi,
                             logic [1:0] chr, logic [1:0] mir, logic pulse);
    mapper_view_t want;
    if (view_q.size() == 0) begin
      $error("result with no request pending");
      errors++;
      return;
    end
    want = view_q.pop_front();
    checked++;
    if (want.pulse) pulses++;
    if (lo !== want.page_lo) begin
      $error("prg_page_lo expected %0d actual %0d", want.page_lo, lo);
      errors++;
    end
    if (hi !== want.page_hi) begin
      $error("prg_page_hi expected %0d actual %0d", want.page_hi, hi);
      errors++;
    end
    if (chr !== want.chr) begin
      $error("chr_bank expected %0d actual %0d", want.chr, chr);
      errors++;
    end
    if (mir !== want.mirror) begin
      $error("mirror_mode expected %0d actual %0d", want.mirror, mir);
      errors++;
    end
    if (pulse !== want.pulse) begin
      $error("irq_pulse expected %0d actual %0d", want.pulse, pulse);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import fbm_pkg::*;

  // spare command code: the block only reports its state
  localparam logic [1:0] CMD_SPARE = 2'd3;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_BURSTY} sink_mode_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        cmd;
  logic [15:0]       addr;
  logic [7:0]        wdata;
  logic              out_valid;
  logic              out_ready;
  logic [PageW-1:0]  prg_page_lo;
  logic [PageW-1:0]  prg_page_hi;
  logic [1:0]        chr_bank;
  logic [1:0]        mirror_mode;
  logic              irq_pulse;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [UnitsW-1:0] cfg_data;

  mapper_scoreboard sb;
  int               burst_left;
  int               live_items;
  int               settings_used;

  ffe_bank_mapper_with_scanline_irq DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .addr        (addr),
    .wdata       (wdata),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .prg_page_lo (prg_page_lo),
    .prg_page_hi (prg_page_hi),
    .chr_bank    (chr_bank),
    .mirror_mode (mirror_mode),
    .irq_pulse   (irq_pulse),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Offer one request, hold it until taken, then pace the sender: stay in the
  // current burst or drop valid for a random gap and start a new burst.
  task automatic push_request(input logic [1:0] c, input logic [15:0] a, input logic [7:0] d);
    in_valid <= 1'b1;
    cmd      <= c;
    addr     <= a;
    wdata    <= d;
    do @(posedge clk); while (!in_ready);
    sb.note_request(c, a, d);
    live_items++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
      // mostly short bursts, now and then a long stretch with no gap
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(60, 25) : $urandom_range(12, 0);
    end
  endtask

  // Drop valid and wait until every owed result has come back, or until the cap runs out.
  task automatic drain_results(input int cap);
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (sb.pending() != 0 && guard < cap) begin
      @(posedge clk);
      guard++;
    end
  endtask

  // Change the ROM size with the block idle.
  task automatic set_rom_units(input logic [UnitsW-1:0] v);
    drain_results(4000);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_units(v);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Random traffic: mostly counter loads followed by runs of ticks so the
  // interrupt fires often, mixed with bank and mirroring writes and noise.
  task automatic random_traffic(input int quota);
    int          stop_at;
    int          pick;
    int          ticks;
    logic [7:0]  hi_byte;
    logic [15:0] noise_addr;
    stop_at = live_items + quota;
    while (live_items < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        // load near the top of the count so a pulse lands within a few ticks
        hi_byte = ($urandom_range(3) == 0) ? 8'($urandom) : (8'hf8 | 8'($urandom_range(7)));
        if ($urandom_range(4) != 0) push_request(CMD_EXP, ADDR_CNT_LO, 8'($urandom));
        push_request(CMD_EXP, ADDR_CNT_HI, hi_byte);
        ticks = $urandom_range(16, 1);
        for (int i = 0; i < ticks; i++) begin
          // break the sequence now and then
          if ($urandom_range(19) == 0) push_request(CMD_EXP, ADDR_IRQ_OFF, 8'($urandom));
          push_request(CMD_TICK, 16'($urandom), 8'($urandom));
        end
      end else if (pick < 55) begin
        push_request(CMD_PRG, 16'($urandom), 8'($urandom));
      end else if (pick < 68) begin
        push_request(CMD_EXP, $urandom_range(1) ? ADDR_MIRROR_A : ADDR_MIRROR_B, 8'($urandom));
      end else if (pick < 83) begin
        push_request(CMD_TICK, 16'($urandom), 8'($urandom));
      end else if (pick < 88) begin
        push_request(CMD_EXP, ADDR_IRQ_OFF, 8'($urandom));
      end else if (pick < 96) begin
        // addresses around the register area, or anywhere at all
        noise_addr = $urandom_range(1) ? {8'h45, 8'($urandom)} : 16'($urandom);
        if ($urandom_range(3) == 0) noise_addr = {8'h42, 8'($urandom)};
        push_request(CMD_EXP, noise_addr, 8'($urandom));
      end else begin
        push_request(CMD_SPARE, 16'($urandom), 8'($urandom));
      end
    end
  endtask

  // Result side: check every accepted result and stall on a pattern that
  // switches between open, coin-flip, sparse and bursty stalls.
  initial begin : result_sink
    sink_mode_t mode;
    int         mode_left;
    int         hold;
    mode      = SINK_OPEN;
    mode_left = 0;
    hold      = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        sb.check_result(prg_page_lo, prg_page_hi, chr_bank, mirror_mode, irq_pulse);
      if (mode_left == 0) begin
        mode      = sink_mode_t'($urandom_range(3));
        mode_left = $urandom_range(150, 30);
      end
      mode_left--;
      case (mode)
        SINK_OPEN:   out_ready <= 1'b1;
        SINK_COIN:   out_ready <= 1'($urandom_range(1));
        SINK_SPARSE: out_ready <= ($urandom_range(3) == 0);
        default: begin
          if (hold > 0) begin
            hold--;
            out_ready <= 1'b0;
          end else begin
            hold = $urandom_range(12, 2);
            out_ready <= 1'b1;
          end
        end
      endcase
    end
  end

  initial begin : stimulus
    logic [UnitsW-1:0] unit_plan [8];
    sb            = new();
    burst_left    = 0;
    live_items    = 0;
    settings_used = 1;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    cmd       <= CMD_EXP;
    addr      <= '0;
    wdata     <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= UNITS_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Bank select extremes at the reset ROM size; upper data bits are don't-care.
    push_request(CMD_PRG, 16'h0000, 8'h00);
    push_request(CMD_PRG, 16'hffff, 8'hff);
    push_request(CMD_PRG, 16'h8000, 8'hc3);
    push_request(CMD_PRG, 16'h7fff, 8'h3c);
    // Mirroring from bit 4 at both addresses, both polarities.
    push_request(CMD_EXP, ADDR_MIRROR_A, 8'h10);
    push_request(CMD_EXP, ADDR_MIRROR_A, 8'hef);
    push_request(CMD_EXP, ADDR_MIRROR_B, 8'hff);
    push_request(CMD_EXP, ADDR_MIRROR_B, 8'h00);
    // Addresses outside the register set are ignored.
    push_request(CMD_EXP, 16'h0000, 8'hff);
    push_request(CMD_EXP, 16'hffff, 8'h10);
    push_request(CMD_EXP, 16'h4500, 8'hff);
    // A tick while disabled changes nothing.
    push_request(CMD_TICK, 16'h0000, 8'h00);
    // A counter loaded with all ones overflows on the next tick, no wrap.
    push_request(CMD_EXP, ADDR_CNT_LO, 8'hff);
    push_request(CMD_EXP, ADDR_CNT_HI, 8'hff);
    push_request(CMD_TICK, 16'hffff, 8'hff);
    // One short of the limit, then over it.
    push_request(CMD_EXP, ADDR_CNT_LO, 8'h79);
    push_request(CMD_EXP, ADDR_CNT_HI, 8'hff);
    push_request(CMD_TICK, 16'h1234, 8'h00);
    push_request(CMD_TICK, 16'h1234, 8'h00);
    // Landing exactly on the limit.
    push_request(CMD_EXP, ADDR_CNT_LO, 8'h7a);
    push_request(CMD_EXP, ADDR_CNT_HI, 8'hff);
    push_request(CMD_TICK, 16'h0001, 8'h01);
    // Disable, then tick: no count, no pulse.
    push_request(CMD_EXP, ADDR_IRQ_OFF, 8'h00);
    push_request(CMD_TICK, 16'h4503, 8'hff);
    // The spare command only reports state.
    push_request(CMD_SPARE, ADDR_CNT_HI, 8'hff);
    // High byte write re-enables from a cleared count.
    push_request(CMD_EXP, ADDR_CNT_HI, 8'h00);
    push_request(CMD_TICK, 16'h0000, 8'h00);

    // ROM size settings: sizes 1 and 255, small odd sizes, the reset size, random nonzero sizes.
    unit_plan = '{8'd1, 8'd255, 8'd3, 8'd7, 8'd15, UNITS_RESET, 8'd1, 8'd1};
    unit_plan[6] = 8'($urandom_range(255, 1));
    unit_plan[7] = 8'($urandom_range(255, 1));
    foreach (unit_plan[i]) begin
      set_rom_units(unit_plan[i]);
      random_traffic(50);
    end

    // Let the last results arrive, then keep waiting to catch strays.
    drain_results(8000);
    repeat (30) @(posedge clk);
    if (sb.pending() != 0) $error("%0d results never arrived", sb.pending());

    $display("Covered %0d requests over %0d ROM size settings;", live_items, settings_used);
    $display("checked %0d results, %0d of them with an interrupt pulse.", sb.checked, sb.pulses);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
